// ===== hw/rtl/ecgc_pkg.sv =====
`default_nettype none
package ecgc_pkg;

    localparam int AVG_TAPS    = 4;
    localparam int MEDIAN_TAPS = 5;
    localparam int QRS_HOLD    = 6;
    localparam int AVG_PW      = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
    localparam int MED_PW      = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
    localparam int AVG_SUM_W   = 24 + AVG_PW;
    localparam int MED_RANK    = MEDIAN_TAPS / 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [14:0] LAST_RAW_RESET = 15'd13200;

    localparam logic signed [16:0] C_NB0   = 17'sd31280;
    localparam logic signed [16:0] C_NB1   = -17'sd19323;
    localparam logic signed [16:0] C_NA1N  = 17'sd19323;
    localparam logic signed [16:0] C_NA2N  = -17'sd29792;
    localparam logic signed [16:0] C_A055  = 17'sd18022;
    localparam logic signed [16:0] C_A055C = 17'sd14746;
    localparam logic signed [16:0] C_A082  = 17'sd26870;
    localparam logic signed [16:0] C_A082C = 17'sd5898;

    localparam logic [2:0] CFG_ADC_PRESENT = 3'd0;
    localparam logic [2:0] CFG_VALID_LOW   = 3'd1;
    localparam logic [2:0] CFG_VALID_HIGH  = 3'd2;
    localparam logic [2:0] CFG_RAW_STEP    = 3'd3;
    localparam logic [2:0] CFG_OUT_STEP    = 3'd4;
    localparam logic [2:0] CFG_QRS_SLOPE   = 3'd5;
    localparam logic [2:0] CFG_HP_COEF     = 3'd6;
    localparam logic [2:0] CFG_BACKOFF     = 3'd7;

    typedef enum logic [2:0] {
        STAT_NO_ADC   = 3'd0,
        STAT_LEADS_OFF = 3'd1,
        STAT_SKIP     = 3'd2,
        STAT_INVALID  = 3'd3,
        STAT_PRIMED   = 3'd4,
        STAT_FILTERED = 3'd5
    } t_status;

    typedef struct packed {
        logic        adc_present;
        logic [14:0] valid_low;
        logic [14:0] valid_high;
        logic [14:0] raw_step_limit;
        logic [22:0] out_step_limit;
        logic [22:0] qrs_slope_limit;
        logic [14:0] hp_coef;
        logic [7:0]  backoff_ms;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic        leads;
        logic [14:0] raw;
    } t_job;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607) r = 24'sd8388607;
        else if (v < -48'sd8388608) r = -24'sd8388608;
        else r = v[23:0];
        return r;
    endfunction

    function automatic logic signed [23:0] round_q15(input logic signed [47:0] acc);
        logic signed [47:0] v;
        v = acc + 48'sd16384;
        return sat24(v >>> 15);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ecg_sample_conditioning_chain_core.sv =====
// channel   dir  fields (low bit first)
// s_axis    in   tdata: adc_sample[15:0] lo_plus lo_minus time_ms[31:0], zero fill
// m_axis    out  tuser: status; tdata: leads raw_code[14:0] display[23:0] detector[23:0]
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
// the front classifies a beat in its accept cycle and queues it (two entries)
// skip, invalid, no-converter, leads-off and re-prime beats go from the queue straight to the output state
// filtered beats pass the average and median states, then the shared multiply-accumulate unit (10 terms)
// synchronous active-low reset; output register holds a result while m_axis stalls
`default_nettype none
module ecg_sample_conditioning_chain_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // adc_sample, lo_plus, lo_minus, time_ms
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // leads_connected, raw_code, display, detector
    output logic [2:0]       m_axis_tuser,   // status
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [22:0] i_cfg_data
);
    import ecgc_pkg::*;

    t_cfg  r_cfg;
    t_job  fjob, qjob;
    logic  full, empty, pop, accept;
    logic  leads;
    logic [14:0] raw;
    logic signed [23:0] disp, det;

    assign s_axis_tready = !full;
    assign accept = s_axis_tvalid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adc_present     <= 1'b1;
            r_cfg.valid_low       <= 15'd800;
            r_cfg.valid_high      <= 15'd27000;
            r_cfg.raw_step_limit  <= 15'd2400;
            r_cfg.out_step_limit  <= 23'd51200;
            r_cfg.qrs_slope_limit <= 23'd15360;
            r_cfg.hp_coef         <= 15'd32211;
            r_cfg.backoff_ms      <= 8'd20;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ADC_PRESENT: r_cfg.adc_present     <= i_cfg_data[0];
                CFG_VALID_LOW:   r_cfg.valid_low       <= i_cfg_data[14:0];
                CFG_VALID_HIGH:  r_cfg.valid_high      <= i_cfg_data[14:0];
                CFG_RAW_STEP:    r_cfg.raw_step_limit  <= i_cfg_data[14:0];
                CFG_OUT_STEP:    r_cfg.out_step_limit  <= i_cfg_data;
                CFG_QRS_SLOPE:   r_cfg.qrs_slope_limit <= i_cfg_data;
                CFG_HP_COEF:     r_cfg.hp_coef         <= i_cfg_data[14:0];
                CFG_BACKOFF:     r_cfg.backoff_ms      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ecgc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_adc      (s_axis_tdata[15:0]),
        .i_lo_plus  (s_axis_tdata[16]),
        .i_lo_minus (s_axis_tdata[17]),
        .i_time     (s_axis_tdata[49:18]),
        .o_job      (fjob)
    );

    ecgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (fjob),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (qjob)
    );

    ecgc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_job    (qjob),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_status (m_axis_tuser),
        .o_leads  (leads),
        .o_raw    (raw),
        .o_disp   (disp),
        .o_det    (det)
    );

    assign m_axis_tdata = {det, disp, raw, leads};

endmodule
`default_nettype wire

// ===== hw/rtl/ecgc_front.sv =====
`default_nettype none
module ecgc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ecgc_pkg::t_cfg  i_cfg,
    input  wire logic            i_accept,
    input  wire logic [15:0]     i_adc,
    input  wire logic            i_lo_plus,
    input  wire logic            i_lo_minus,
    input  wire logic [31:0]     i_time,
    output ecgc_pkg::t_job       o_job
);
    import ecgc_pkg::*;

    logic [2:0]  r_ct, r_lt, n_ct, n_lt;
    logic        r_stable, n_stable, r_primed, n_primed;
    logic [1:0]  r_run, n_run;
    logic [31:0] r_until, n_until;
    logic [14:0] r_last, n_last;
    logic        conn;
    logic signed [16:0] step, lim, clamp;
    t_job        job;

    assign conn = !(i_lo_plus || i_lo_minus);

    always_comb begin
        n_ct     = r_ct;
        n_lt     = r_lt;
        n_stable = r_stable;
        n_primed = r_primed;
        n_run    = r_run;
        n_until  = r_until;
        n_last   = r_last;
        step     = $signed({1'b0, i_adc}) - $signed({2'b0, r_last});
        lim      = $signed({2'b0, i_cfg.raw_step_limit});
        clamp    = $signed({1'b0, i_adc});
        job.status = STAT_NO_ADC;
        job.leads  = 1'b0;
        job.raw    = 15'd0;
        if (i_cfg.adc_present) begin
            if (conn) begin
                n_ct = (r_ct < 3'd5) ? r_ct + 3'd1 : r_ct;
                n_lt = 3'd0;
            end else begin
                n_lt = (r_lt < 3'd5) ? r_lt + 3'd1 : r_lt;
                n_ct = 3'd0;
            end
            if (n_ct >= 3'd3) n_stable = 1'b1;
            else if (n_lt >= 3'd3) n_stable = 1'b0;
            job.leads = n_stable;
            if (!n_stable) begin
                n_primed   = 1'b0;
                job.status = STAT_LEADS_OFF;
            end else if (i_time < r_until) begin
                job.status = STAT_SKIP;
                job.raw    = r_last;
            end else if (i_adc[15] || i_adc[14:0] < i_cfg.valid_low
                         || i_adc[14:0] >= i_cfg.valid_high) begin
                job.status = STAT_INVALID;
                job.raw    = r_last;
                if (r_run == 2'd2) begin
                    n_run   = 2'd0;
                    n_until = i_time + {24'd0, i_cfg.backoff_ms};
                end else begin
                    n_run = r_run + 2'd1;
                end
            end else begin
                n_run = 2'd0;
                if (step > lim) clamp = $signed({2'b0, r_last}) + lim;
                else if (step < -lim) clamp = $signed({2'b0, r_last}) - lim;
                n_last     = clamp[14:0];
                job.raw    = clamp[14:0];
                job.status = r_primed ? STAT_FILTERED : STAT_PRIMED;
                n_primed   = 1'b1;
            end
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ct     <= '0;
            r_lt     <= '0;
            r_stable <= 1'b0;
            r_primed <= 1'b0;
            r_run    <= '0;
            r_until  <= '0;
            r_last   <= LAST_RAW_RESET;
        end else if (i_accept) begin
            r_ct     <= n_ct;
            r_lt     <= n_lt;
            r_stable <= n_stable;
            r_primed <= n_primed;
            r_run    <= n_run;
            r_until  <= n_until;
            r_last   <= n_last;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ecgc_queue.sv =====
`default_nettype none
module ecgc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ecgc_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output ecgc_pkg::t_job      o_job
);
    import ecgc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job        r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ecgc_back.sv =====
`default_nettype none
module ecgc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ecgc_pkg::t_cfg  i_cfg,
    input  wire logic            i_empty,
    input  wire ecgc_pkg::t_job  i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [2:0]           o_status,
    output logic                 o_leads,
    output logic [14:0]          o_raw,
    output logic signed [23:0]   o_disp,
    output logic signed [23:0]   o_det
);
    import ecgc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MA, S_MED, S_MUL, S_ACC, S_RND, S_OUT
    } t_state;

    t_state r_state;
    logic signed [23:0] r_avg [AVG_TAPS];
    logic signed [23:0] r_mtap [MEDIAN_TAPS];
    logic [AVG_PW-1:0] r_apos;
    logic [MED_PW-1:0] r_mpos;
    logic signed [23:0] r_ni0, r_ni1, r_no0, r_no1, r_hli, r_hlo;
    logic signed [23:0] r_alp, r_ali, r_detlp, r_disp, r_med, r_hp, r_x;
    logic [2:0] r_hold;
    logic signed [25:0] r_hpd;
    logic signed [42:0] r_prod;
    logic signed [47:0] r_acc;
    logic [3:0] r_term;
    t_status r_rs;
    logic r_rl;
    logic [14:0] r_rr;
    logic signed [23:0] r_rdisp, r_rdet;

    logic signed [AVG_SUM_W-1:0] sum, ma_w;
    logic signed [23:0] ma, med, rnd, jx;
    logic signed [25:0] op_a;
    logic signed [16:0] op_b;
    logic signed [24:0] slope;
    logic signed [25:0] dd, lim, lo_b;
    logic [2:0] hold_n;
    logic [3:0] rank;

    assign jx  = $signed({4'b0, i_job.raw, 5'b0});
    assign rnd = round_q15(r_acc);

    always_comb begin
        sum = '0;
        for (int i = 0; i < AVG_TAPS; i++) begin
            if (r_apos == AVG_PW'(i)) sum = sum + AVG_SUM_W'(r_x);
            else sum = sum + AVG_SUM_W'(r_avg[i]);
        end
        ma_w = sum / AVG_SUM_W'(AVG_TAPS);
        ma   = ma_w[23:0];
    end

    always_comb begin
        med = r_mtap[0];
        for (int i = 0; i < MEDIAN_TAPS; i++) begin
            rank = '0;
            for (int j = 0; j < MEDIAN_TAPS; j++) begin
                if (r_mtap[j] < r_mtap[i] || (r_mtap[j] == r_mtap[i] && j < i))
                    rank = rank + 4'd1;
            end
            if (rank == 4'(MED_RANK)) med = r_mtap[i];
        end
    end

    always_comb begin
        case (r_term)
            4'd0: begin op_a = 26'(r_med); op_b = C_NB0; end
            4'd1: begin op_a = 26'(r_ni0); op_b = C_NB1; end
            4'd2: begin op_a = 26'(r_ni1); op_b = C_NB0; end
            4'd3: begin op_a = 26'(r_no0); op_b = C_NA1N; end
            4'd4: begin op_a = 26'(r_no1); op_b = C_NA2N; end
            4'd5: begin op_a = r_hpd; op_b = $signed({2'b0, i_cfg.hp_coef}); end
            4'd6: begin op_a = 26'(r_detlp); op_b = C_A055; end
            4'd7: begin op_a = 26'(r_hp); op_b = C_A055C; end
            4'd8: begin op_a = 26'(r_alp); op_b = (r_hold != 3'd0) ? C_A055 : C_A082; end
            4'd9: begin op_a = 26'(r_hp); op_b = (r_hold != 3'd0) ? C_A055C : C_A082C; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb begin
        slope = 25'(r_hp) - 25'(r_ali);
        if (slope < 0) slope = -slope;
        if (slope > $signed({2'b0, i_cfg.qrs_slope_limit})) hold_n = 3'(QRS_HOLD);
        else if (r_hold != 3'd0) hold_n = r_hold - 3'd1;
        else hold_n = r_hold;
        lim = $signed({3'b0, i_cfg.out_step_limit});
        dd  = 26'(rnd) - 26'(r_disp);
        lo_b = 26'(rnd);
        if (dd > lim) lo_b = 26'(r_disp) + lim;
        else if (dd < -lim) lo_b = 26'(r_disp) - lim;
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_apos  <= '0;
            r_mpos  <= '0;
            r_hli   <= '0;
            r_hlo   <= '0;
            r_alp   <= '0;
            r_ali   <= '0;
            r_hold  <= '0;
            r_detlp <= '0;
            r_disp  <= '0;
            r_term  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_OUT) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_rs    <= i_job.status;
                        r_rl    <= i_job.leads;
                        r_rr    <= i_job.raw;
                        r_x     <= jx;
                        if (i_job.status inside {STAT_SKIP, STAT_INVALID}) begin
                            r_rdisp <= r_disp;
                            r_rdet  <= r_detlp;
                        end else begin
                            r_rdisp <= '0;
                            r_rdet  <= '0;
                        end
                        r_state <= (i_job.status == STAT_FILTERED) ? S_MA : S_OUT;
                        case (i_job.status)
                            STAT_PRIMED: begin
                                for (int i = 0; i < AVG_TAPS; i++) r_avg[i] <= jx;
                                for (int i = 0; i < MEDIAN_TAPS; i++) r_mtap[i] <= jx;
                                r_apos  <= '0;
                                r_mpos  <= '0;
                                r_hli   <= jx;
                                r_hlo   <= '0;
                                r_alp   <= '0;
                                r_detlp <= '0;
                                r_ni0   <= jx;
                                r_ni1   <= jx;
                                r_no0   <= jx;
                                r_no1   <= jx;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MA: begin
                    r_avg[r_apos]  <= r_x;
                    r_mtap[r_mpos] <= ma;
                    r_apos <= (r_apos == AVG_PW'(AVG_TAPS - 1)) ? '0 : r_apos + 1'b1;
                    r_mpos <= (r_mpos == MED_PW'(MEDIAN_TAPS - 1)) ? '0 : r_mpos + 1'b1;
                    r_state <= S_MED;
                end
                S_MED: begin
                    r_med   <= med;
                    r_acc   <= '0;
                    r_term  <= 4'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= op_a * op_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + 48'(r_prod);
                    if (r_term == 4'd4 || r_term == 4'd5 || r_term == 4'd7
                        || r_term == 4'd9) begin
                        r_state <= S_RND;
                    end else begin
                        r_term  <= r_term + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_RND: begin
                    r_acc <= '0;
                    if (r_term == 4'd9) begin
                        r_state <= S_OUT;
                    end else begin
                        r_term  <= r_term + 4'd1;
                        r_state <= S_MUL;
                    end
                    case (r_term)
                        4'd4: begin
                            r_ni1 <= r_ni0;
                            r_ni0 <= r_med;
                            r_no1 <= r_no0;
                            r_no0 <= rnd;
                            r_hpd <= 26'(r_hlo) + 26'(rnd) - 26'(r_hli);
                            r_hli <= rnd;
                        end
                        4'd5: begin
                            r_hlo <= rnd;
                            r_hp  <= rnd;
                        end
                        4'd7: begin
                            r_detlp <= rnd;
                            r_rdet  <= rnd;
                            r_ali   <= r_hp;
                            r_hold  <= hold_n;
                        end
                        default: begin
                            r_alp   <= rnd;
                            r_disp  <= sat24(48'(lo_b));
                            r_rdisp <= sat24(48'(lo_b));
                        end
                    endcase
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid  <= 1'b1;
                        o_status <= r_rs;
                        o_leads  <= r_rl;
                        o_raw    <= r_rr;
                        o_disp   <= r_rdisp;
                        o_det    <= r_rdet;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_term <= 4'd9) else $error("term index out of range");
    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold <= 3'(QRS_HOLD)) else $error("qrs hold out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != S_IDLE) else $error("pop without leaving idle");
    a_last_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND && r_term == 4'd9) |=> r_state == S_OUT)
        else $error("final round did not reach output");

endmodule
`default_nettype wire

// ===== tb/ecg_sample_conditioning_chain_core_test.sv =====
`default_nettype none
module ecg_sample_conditioning_chain_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ecgc_pkg::*;

    typedef struct {
        logic signed [15:0] adc;
        logic               lo_p;
        logic               lo_m;
        logic [31:0]        now;
    } t_sample;

    typedef struct {
        t_status            status;
        logic               leads;
        logic [14:0]        raw;
        logic signed [23:0] disp;
        logic signed [23:0] det;
    } t_cond;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [22:0] i_cfg_data = '0;

    ecg_sample_conditioning_chain_core dut (.*);

    initial forever #6 i_clk = ~i_clk;

    // predictor state
    logic        p_present;
    logic [14:0] p_vlow, p_vhigh, p_rstep, p_alpha;
    logic [22:0] p_ostep, p_qslope;
    logic [7:0]  p_boff;
    longint      avg_q[AVG_TAPS];
    longint      med_q[MEDIAN_TAPS];
    int          avg_at, med_at;
    longint      nin0, nin1, nout0, nout1, hp_in, hp_out, alp_out, alp_in, det_out, disp_last;
    int          qhold;
    logic [14:0] raw_last;
    int          bad_run;
    logic [31:0] hold_until;
    int          on_ticks, off_ticks;
    bit          contact, primed;

    t_sample sample_q[$];
    t_cond   cond_q[$];
    int      sent;
    int      errors = 0;
    int      idle_pct = 0, stall_pct = 0;
    int      hold_off = 0;
    bit      stim_done = 0;
    longint  cycles = 0;

    // handshake as seen at the last rising edge
    logic s_axis_tready_q = 1'b0;

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint rnd15(longint acc);
        longint v = acc + 16384;
        longint q;
        if (v >= 0) q = v / 32768;
        else q = -((-v + 32767) / 32768);
        return clip24(q);
    endfunction

    function automatic longint median_now();
        longint s[MEDIAN_TAPS];
        longint k;
        int j;
        for (int i = 0; i < MEDIAN_TAPS; i++) s[i] = med_q[i];
        for (int i = 1; i < MEDIAN_TAPS; i++) begin
            k = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > k) begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = k;
        end
        return s[MEDIAN_TAPS / 2];
    endfunction

    task automatic predictor_reset();
        p_present = 1; p_vlow = 800; p_vhigh = 27000; p_rstep = 2400;
        p_ostep = 51200; p_qslope = 15360; p_alpha = 32211; p_boff = 20;
        foreach (avg_q[i]) avg_q[i] = 0;
        foreach (med_q[i]) med_q[i] = 0;
        avg_at = 0; med_at = 0;
        nin0 = 0; nin1 = 0; nout0 = 0; nout1 = 0; hp_in = 0; hp_out = 0;
        alp_out = 0; alp_in = 0; det_out = 0; disp_last = 0; qhold = 0;
        raw_last = LAST_RAW_RESET; bad_run = 0; hold_until = 0;
        on_ticks = 0; off_ticks = 0; contact = 0; primed = 0;
    endtask

    function automatic t_cond condition(t_sample s);
        t_cond r;
        longint a, stp, rr, x, sum, ma, md, nt, hp, lp, sl, d;
        r = '{STAT_NO_ADC, 1'b0, 15'd0, 24'sd0, 24'sd0};
        if (!p_present) return r;
        a = s.adc;
        if (!(s.lo_p || s.lo_m)) begin
            if (on_ticks < 5) on_ticks++;
            off_ticks = 0;
        end else begin
            if (off_ticks < 5) off_ticks++;
            on_ticks = 0;
        end
        if (on_ticks >= 3) contact = 1;
        else if (off_ticks >= 3) contact = 0;
        r.leads = contact;
        if (!contact) begin
            primed = 0;
            r.status = STAT_LEADS_OFF;
        end else if (s.now < hold_until) begin
            r.status = STAT_SKIP;
            r.raw = raw_last; r.disp = disp_last; r.det = det_out;
        end else if (a < 0 || a < p_vlow || a >= p_vhigh) begin
            bad_run++;
            if (bad_run >= 3) begin
                hold_until = s.now + p_boff;
                bad_run = 0;
            end
            r.status = STAT_INVALID;
            r.raw = raw_last; r.disp = disp_last; r.det = det_out;
        end else begin
            bad_run = 0;
            stp = a - longint'(raw_last);
            rr = a;
            if (stp > longint'(p_rstep)) rr = raw_last + p_rstep;
            else if (stp < -longint'(p_rstep)) rr = longint'(raw_last) - p_rstep;
            raw_last = rr[14:0];
            r.raw = raw_last;
            x = longint'(raw_last) * 32;
            if (!primed) begin
                foreach (avg_q[i]) avg_q[i] = x;
                foreach (med_q[i]) med_q[i] = x;
                avg_at = 0; med_at = 0;
                hp_in = x; hp_out = 0; alp_out = 0; det_out = 0;
                nin0 = x; nin1 = x; nout0 = x; nout1 = x;
                primed = 1;
                r.status = STAT_PRIMED;
            end else begin
                avg_q[avg_at] = x;
                avg_at = (avg_at + 1) % AVG_TAPS;
                sum = 0;
                foreach (avg_q[i]) sum += avg_q[i];
                ma = sum / AVG_TAPS;
                med_q[med_at] = ma;
                med_at = (med_at + 1) % MEDIAN_TAPS;
                md = median_now();
                nt = rnd15(31280 * md - 19323 * nin0 + 31280 * nin1
                           + 19323 * nout0 - 29792 * nout1);
                nin1 = nin0; nin0 = md; nout1 = nout0; nout0 = nt;
                hp = rnd15(longint'(p_alpha) * (hp_out + nt - hp_in));
                hp_in = nt; hp_out = hp;
                det_out = rnd15(18022 * det_out + 14746 * hp);
                r.det = det_out;
                sl = hp - alp_in;
                if (sl < 0) sl = -sl;
                alp_in = hp;
                if (sl > longint'(p_qslope)) qhold = QRS_HOLD;
                else if (qhold > 0) qhold--;
                if (qhold > 0) lp = rnd15(18022 * alp_out + 14746 * hp);
                else lp = rnd15(26870 * alp_out + 5898 * hp);
                alp_out = lp;
                d = lp - disp_last;
                if (d > longint'(p_ostep)) lp = clip24(disp_last + longint'(p_ostep));
                else if (d < -longint'(p_ostep)) lp = clip24(disp_last - longint'(p_ostep));
                disp_last = lp;
                r.disp = lp;
                r.status = STAT_FILTERED;
            end
        end
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready_q) begin
                sent++;
                cond_q.push_back(condition(sample_q.pop_front()));
            end
            if (sample_q.size() > 0 && (!s_axis_tvalid || s_axis_tready_q)) begin
                if ($urandom_range(99) >= idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, sample_q[0].now, sample_q[0].lo_m,
                                     sample_q[0].lo_p, sample_q[0].adc};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end else if (sample_q.size() == 0 && s_axis_tready_q) begin
                s_axis_tvalid <= 1'b0;
            end
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // long receiver hold-off countdown
    always @(negedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    always @(posedge i_clk) begin
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        cycles <= cycles + 1;
    end

    // monitor
    always @(posedge i_clk) begin
        t_cond e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cond_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat status %0d", m_axis_tuser);
            end else begin
                e = cond_q.pop_front();
                if (m_axis_tuser != e.status || m_axis_tdata[0] != e.leads ||
                    m_axis_tdata[15:1] != e.raw || m_axis_tdata[39:16] != e.disp ||
                    m_axis_tdata[63:40] != e.det) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 e.status, e.leads, e.raw, e.disp, e.det, m_axis_tuser,
                                 m_axis_tdata[0], m_axis_tdata[15:1],
                                 $signed(m_axis_tdata[39:16]), $signed(m_axis_tdata[63:40]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 3000000) begin
            $display("ecg_sample_conditioning_chain_core test failed");
            $finish;
        end
    end

    task automatic set_reg(logic [2:0] idx, logic [22:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        case (idx)
            CFG_ADC_PRESENT: p_present = val[0];
            CFG_VALID_LOW:   p_vlow = val[14:0];
            CFG_VALID_HIGH:  p_vhigh = val[14:0];
            CFG_RAW_STEP:    p_rstep = val[14:0];
            CFG_OUT_STEP:    p_ostep = val;
            CFG_QRS_SLOPE:   p_qslope = val;
            CFG_HP_COEF:     p_alpha = val[14:0];
            CFG_BACKOFF:     p_boff = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (sample_q.size() == 0 && !s_axis_tvalid && cond_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic push(logic signed [15:0] adc, bit lp, bit lm, logic [31:0] now);
        sample_q.push_back('{adc, lp, lm, now});
    endtask

    logic [31:0] clock_ms = 0;

    // mostly connected, in-range waveform with occasional noise
    task automatic random_run(int n);
        int base;
        base = $urandom_range(2000, 25000);
        for (int i = 0; i < n; i++) begin
            int r = $urandom_range(99);
            clock_ms += $urandom_range(0, 8);
            if (r < 4) push(16'($urandom), 1, 1'($urandom), clock_ms);
            else if (r < 8) push(16'($urandom), 1'($urandom), 1, clock_ms);
            else if (r < 14) push(16'($urandom), 0, 0, clock_ms);
            else if (r < 18) push(16'($urandom), 0, 0, $urandom);
            else begin
                if ($urandom_range(9) == 0) base = $urandom_range(800, 27000);
                base += $signed($urandom_range(0, 1200)) - 600;
                if ($urandom_range(15) == 0) base += $signed($urandom_range(0, 12000)) - 6000;
                if (base < 0) base = 0;
                if (base > 32767) base = 32767;
                push(16'(base), 0, 0, clock_ms);
            end
        end
    endtask

    initial begin
        predictor_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed part
        for (int i = 0; i < 3; i++) push(5000, 1, 0, 0);
        for (int i = 0; i < 3; i++) push(5000, 0, 0, 1);
        push(32767, 0, 0, 2);
        push(-32768, 0, 0, 3);
        push(100, 0, 0, 4);
        push(-1, 0, 0, 5);
        push(20000, 0, 0, 6);
        push(20000, 0, 0, 30);
        push(0, 0, 0, 31);
        push(26999, 0, 0, 32);
        push(800, 0, 0, 33);
        push(26000, 0, 0, 34);
        push(1000, 0, 0, 35);
        push(5000, 0, 1, 36);
        push(5000, 1, 1, 37);
        push(5000, 0, 1, 38);
        for (int i = 0; i < 3; i++) push(9000, 0, 0, 32'hFFFF_FFF0 + i);
        push(27000, 0, 0, 32'hFFFF_FFFF);
        drain();
        set_reg(CFG_BACKOFF, 255);
        set_reg(CFG_RAW_STEP, 32767);
        set_reg(CFG_OUT_STEP, 23'h7FFFFF);
        set_reg(CFG_QRS_SLOPE, 0);
        set_reg(CFG_HP_COEF, 32767);
        set_reg(CFG_VALID_LOW, 0);
        set_reg(CFG_VALID_HIGH, 32767);
        clock_ms = 0;
        random_run(250);
        drain();
        set_reg(CFG_ADC_PRESENT, 0);
        random_run(40);
        drain();
        set_reg(CFG_ADC_PRESENT, 1);
        set_reg(CFG_RAW_STEP, 0);
        set_reg(CFG_OUT_STEP, 0);
        set_reg(CFG_QRS_SLOPE, 23'h7FFFFF);
        set_reg(CFG_HP_COEF, 0);
        set_reg(CFG_BACKOFF, 0);
        idle_pct = 65;
        random_run(250);
        drain();
        set_reg(CFG_VALID_LOW, 800);
        set_reg(CFG_VALID_HIGH, 27000);
        set_reg(CFG_RAW_STEP, 2400);
        set_reg(CFG_OUT_STEP, 51200);
        set_reg(CFG_QRS_SLOPE, 15360);
        set_reg(CFG_HP_COEF, 32211);
        set_reg(CFG_BACKOFF, 20);
        idle_pct = 0; stall_pct = 65;
        random_run(350);
        drain();
        idle_pct = 36; stall_pct = 36;
        set_reg(CFG_RAW_STEP, 23'($urandom_range(100, 5000)));
        set_reg(CFG_QRS_SLOPE, 23'($urandom_range(1000, 40000)));
        random_run(350);
        drain();
        idle_pct = 0; stall_pct = 0;
        hold_off = 400;
        random_run(350);
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) $display("ecg_sample_conditioning_chain_core test passed");
        else $display("ecg_sample_conditioning_chain_core test failed");
        $finish;
    end
endmodule
`default_nettype wire
